@@ hdl/laplace_filter_3x3_rgb_assert.svh @@
// Assertion macros shared by the Laplacian filter RTL.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef LAPLACE_FILTER_3X3_RGB_ASSERT_SVH
`define LAPLACE_FILTER_3X3_RGB_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define LF3_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define LF3_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define LF3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lf3_pkg.sv @@
// Shared constants and types of the 3x3 Laplacian RGB filter.
// No dependencies; the RTL files and interfaces refer to it by scoped names, the testbench imports it.
package lf3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int CHAN_W   = 8;
   localparam int DIM_W    = 11;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   // Input row count runs a few rows past the frame while trailing items drain.
   localparam int IN_ROW_W = $clog2(MAX_HEIGHT + 4);
   localparam int CSR_IDX_W = 2;

   // Kernel normalisation: divide by 8, then centre on mid-grey.
   localparam int DIV_SHIFT     = 3;
   localparam int RESULT_OFFSET = 128;

   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // One column of the two line stores: two rows up and one row up.
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } line_rd_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      line_pair_type    data;
   } line_wr_type;

endpackage

@@ hdl/lf3_if.sv @@
// Handshake channels of the 3x3 Laplacian RGB filter: pixel input, result output, CSR writes.
// Depends on lf3_pkg for field types and widths.
interface lf3_req_if;
   logic                           valid;
   logic                           ready;
   lf3_pkg::cmd_type               command;
   logic [lf3_pkg::CHAN_W-1:0]     red_in;
   logic [lf3_pkg::CHAN_W-1:0]     green_in;
   logic [lf3_pkg::CHAN_W-1:0]     blue_in;

   modport source (output valid, command, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface lf3_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lf3_pkg::CHAN_W-1:0]     red_out;
   logic [lf3_pkg::CHAN_W-1:0]     green_out;
   logic [lf3_pkg::CHAN_W-1:0]     blue_out;
   logic                           frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface lf3_csr_if;
   logic                           valid;
   logic                           ready;
   lf3_pkg::csr_index_type         index;
   logic [lf3_pkg::DIM_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/laplace_filter_3x3_rgb.sv @@
// 3x3 four-neighbour Laplacian filter for a raster-order RGB888 pixel stream.
// Depends on lf3_pkg, the channel interfaces, lf3_line_ram and the assertion macros.
//
// The block takes one item per clock cycle unless a result stalls in the output
// register; the single-port read and single-port write of the line store, both
// used once per item, set the figure. The other exception is a flush in a frame
// of a single row whose first flush shifts the window twice: that item holds off
// the next one while its second shift issues. Each operation waits in stage one
// and its result in the output register; results lag the pixel stream by one
// row plus one pixel, so the last row plus one pixels of a frame are pushed out
// by flush items; the final result of a frame carries frame_end, after which the
// next pixel opens a new frame. Pixels sent once the frame is fully in, and
// flushes sent before, are taken and dropped. Interior pixels give
// (4*centre - up - down - left - right)/8 + 128 per channel, truncated toward
// zero, while pixels in the first or last row or column pass through unchanged.
// The line store is not cleared after reset and needs no clearing pass: no
// result ever reads a column that the current stream has not written. A write
// of frame_width or frame_height (clamped to 1..1024) restarts the frame; it is
// meant to be issued only while the block is idle.
`include "laplace_filter_3x3_rgb_assert.svh"

module laplace_filter_3x3_rgb (
   input  logic      clock,
   input  logic      reset,
   lf3_req_if.sink   req_ch,
   lf3_rsp_if.source rsp_ch,
   lf3_csr_if.sink   csr_ch
);

   // Operation held between the line store read and the window update.
   typedef struct packed {
      lf3_pkg::pixel_type          pix;
      logic [lf3_pkg::COL_W-1:0]   col;
      logic                        emit;
      logic                        border;
      logic                        last;
   } push_op_type;

   typedef struct packed {
      lf3_pkg::pixel_type pix;
      logic               frame_end;
   } out_item_type;

   // Clamp a frame dimension to 1..limit and return it minus one.
   function automatic logic [lf3_pkg::COL_W-1:0] dim_last(
      input logic [lf3_pkg::DIM_W-1:0] value,
      input logic [lf3_pkg::DIM_W-1:0] limit
   );
      logic [lf3_pkg::DIM_W-1:0] clamped;
      clamped = value;
      if (value == '0) begin
         clamped = lf3_pkg::DIM_W'(1);
      end else if (value > limit) begin
         clamped = limit;
      end
      return lf3_pkg::COL_W'(clamped - lf3_pkg::DIM_W'(1));
   endfunction

   // One channel of the kernel, divided by eight toward zero and offset to mid-grey.
   function automatic logic [lf3_pkg::CHAN_W-1:0] lap_chan(
      input logic [lf3_pkg::CHAN_W-1:0] c,
      input logic [lf3_pkg::CHAN_W-1:0] u,
      input logic [lf3_pkg::CHAN_W-1:0] d,
      input logic [lf3_pkg::CHAN_W-1:0] l,
      input logic [lf3_pkg::CHAN_W-1:0] r
   );
      logic [lf3_pkg::CHAN_W+1:0]          ring;
      logic signed [lf3_pkg::CHAN_W+3:0]   s;
      logic signed [lf3_pkg::CHAN_W+3:0]   q;
      ring = {2'b00, u} + {2'b00, d} + {2'b00, l} + {2'b00, r};
      s = $signed({2'b00, c, 2'b00}) - $signed({2'b00, ring});
      if (s[lf3_pkg::CHAN_W+3]) begin
         q = (s + $signed((lf3_pkg::CHAN_W+4)'((1 << lf3_pkg::DIV_SHIFT) - 1)))
             >>> lf3_pkg::DIV_SHIFT;
      end else begin
         q = s >>> lf3_pkg::DIV_SHIFT;
      end
      return lf3_pkg::CHAN_W'(q + $signed((lf3_pkg::CHAN_W+4)'(lf3_pkg::RESULT_OFFSET)));
   endfunction

   // Frame geometry, stored as last column and last row.
   logic [lf3_pkg::COL_W-1:0]    w_last_ff;
   logic [lf3_pkg::ROW_W-1:0]    h_last_ff;

   // Position counters of the input stream and of the next result.
   logic [lf3_pkg::COL_W-1:0]    in_col_ff,  in_col_in;
   logic [lf3_pkg::IN_ROW_W-1:0] in_row_ff,  in_row_in;
   logic [lf3_pkg::COL_W-1:0]    out_col_ff, out_col_in;
   logic [lf3_pkg::ROW_W-1:0]    out_row_ff, out_row_in;
   logic                         pend_ff,    pend_in;

   logic                         s1_valid_ff, s1_valid_in;
   push_op_type                  s1_op_ff;
   push_op_type                  issue_op;

   // Window registers; the two left corners are never read by the kernel.
   lf3_pkg::pixel_type win_top_mid_ff, win_top_right_ff;
   lf3_pkg::pixel_type win_mid_left_ff, win_centre_ff, win_mid_right_ff;
   lf3_pkg::pixel_type win_bot_mid_ff, win_bot_right_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   out_item_type                 rsp_data_ff;
   out_item_type                 result;

   lf3_pkg::line_rd_type         line_rd;
   lf3_pkg::line_wr_type         line_wr;
   lf3_pkg::line_pair_type       line_q;

   logic csr_fire, csr_hit, req_fire, s1_fire, slot_free;
   logic row_open, is_flush, col_wrap, out_border, out_last;
   logic do_push, do_emit, set_pend;
   lf3_pkg::pixel_type push_pix;

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign csr_hit  = csr_fire && ((csr_ch.index == lf3_pkg::CSR_FRAME_WIDTH) ||
                                  (csr_ch.index == lf3_pkg::CSR_FRAME_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= lf3_pkg::COL_W'(lf3_pkg::FRAME_WIDTH_RESET - 1);
         h_last_ff <= lf3_pkg::ROW_W'(lf3_pkg::FRAME_HEIGHT_RESET - 1);
      end else if (csr_fire) begin
         unique case (csr_ch.index)
            lf3_pkg::CSR_FRAME_WIDTH: begin
               w_last_ff <= dim_last(csr_ch.data, lf3_pkg::DIM_W'(lf3_pkg::MAX_WIDTH));
            end
            lf3_pkg::CSR_FRAME_HEIGHT: begin
               h_last_ff <= lf3_pkg::ROW_W'(
                  dim_last(csr_ch.data, lf3_pkg::DIM_W'(lf3_pkg::MAX_HEIGHT)));
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Issue: decide what an item does and read the line store for its column
   // ------------------------------------------------------------------------
   // Stage one may take a new operation when it is empty or hands its own on.
   // It only waits when its operation carries a result and the output register
   // is full and not being drained.
   assign s1_fire   = s1_valid_ff && (!s1_op_ff.emit || !rsp_valid_ff || rsp_ch.ready);
   assign slot_free = !s1_valid_ff || s1_fire;
   assign req_ch.ready = slot_free && !pend_ff;
   assign req_fire  = req_ch.valid && req_ch.ready;

   assign row_open = in_row_ff <= lf3_pkg::IN_ROW_W'(h_last_ff);
   assign is_flush = req_ch.command == lf3_pkg::CMD_FLUSH;
   assign col_wrap = in_col_ff == w_last_ff;

   assign out_border = (out_row_ff == '0) || (out_row_ff == h_last_ff) ||
                       (out_col_ff == '0) || (out_col_ff == w_last_ff);
   assign out_last   = (out_row_ff == h_last_ff) && (out_col_ff == w_last_ff);

   always_comb begin
      do_push  = 1'b0;
      do_emit  = 1'b0;
      set_pend = 1'b0;
      push_pix = '0;
      if (pend_ff) begin
         // Second window shift of the first flush in a single-row frame.
         if (slot_free) begin
            do_push = 1'b1;
            do_emit = 1'b1;
         end
      end else if (req_fire) begin
         if (!is_flush) begin
            if (row_open) begin
               do_push  = 1'b1;
               push_pix = '{red: req_ch.red_in, green: req_ch.green_in,
                            blue: req_ch.blue_in};
               // Results start once the stream is one row and one pixel ahead.
               do_emit  = (in_row_ff >= lf3_pkg::IN_ROW_W'(2)) ||
                          ((in_row_ff == lf3_pkg::IN_ROW_W'(1)) && (in_col_ff != '0));
            end
         end else if (!row_open) begin
            do_push = 1'b1;
            if ((in_row_ff == lf3_pkg::IN_ROW_W'(1)) && (in_col_ff == '0)) begin
               set_pend = 1'b1;
            end else begin
               do_emit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      issue_op.pix    = push_pix;
      issue_op.col    = in_col_ff;
      issue_op.emit   = do_emit;
      issue_op.border = out_border;
      issue_op.last   = out_last;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_hit) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (do_push) begin
         if (do_emit && out_last) begin
            // Frame complete: everything restarts at the top left corner.
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + lf3_pkg::IN_ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + lf3_pkg::COL_W'(1);
            end
            if (do_emit) begin
               if (out_col_ff == w_last_ff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + lf3_pkg::ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + lf3_pkg::COL_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      pend_in = pend_ff;
      if (set_pend) begin
         pend_in = 1'b1;
      end else if (pend_ff && slot_free) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (do_push) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pend_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pend_ff     <= pend_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         s1_op_ff <= issue_op;
      end
   end

   // ------------------------------------------------------------------------
   // Line store: read at issue, written back when the operation leaves stage one
   // ------------------------------------------------------------------------
   always_comb begin
      line_rd.en   = do_push;
      line_rd.addr = in_col_ff;
      line_wr.en   = s1_fire;
      line_wr.addr = s1_op_ff.col;
      // The row one up moves two up, and the new pixel becomes the row one up.
      line_wr.data = '{upper: line_q.middle, middle: s1_op_ff.pix};
   end

   lf3_line_ram u_line_ram (
      .clock   (clock),
      .reset   (reset),
      .rd      (line_rd),
      .rd_data (line_q),
      .wr      (line_wr)
   );

   // ------------------------------------------------------------------------
   // Window shift and kernel
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         win_top_mid_ff   <= win_top_right_ff;
         win_top_right_ff <= line_q.upper;
         win_mid_left_ff  <= win_centre_ff;
         win_centre_ff    <= win_mid_right_ff;
         win_mid_right_ff <= line_q.middle;
         win_bot_mid_ff   <= win_bot_right_ff;
         win_bot_right_ff <= s1_op_ff.pix;
      end
   end

   // The kernel works on the window as it stands after this shift, so each tap
   // is taken from the register that is about to move into its place.
   always_comb begin
      result.frame_end = s1_op_ff.last;
      if (s1_op_ff.border) begin
         result.pix = win_mid_right_ff;
      end else begin
         result.pix.red   = lap_chan(win_mid_right_ff.red,   win_top_right_ff.red,
                                     win_bot_right_ff.red,   win_centre_ff.red,
                                     line_q.middle.red);
         result.pix.green = lap_chan(win_mid_right_ff.green, win_top_right_ff.green,
                                     win_bot_right_ff.green, win_centre_ff.green,
                                     line_q.middle.green);
         result.pix.blue  = lap_chan(win_mid_right_ff.blue,  win_top_right_ff.blue,
                                     win_bot_right_ff.blue,  win_centre_ff.blue,
                                     line_q.middle.blue);
      end
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_op_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_op_ff.emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.red_out   = rsp_data_ff.pix.red;
   assign rsp_ch.green_out = rsp_data_ff.pix.green;
   assign rsp_ch.blue_out  = rsp_data_ff.pix.blue;
   assign rsp_ch.frame_end = rsp_data_ff.frame_end;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `LF3_ASSERT_ALWAYS(a_out_pos_in_frame, (out_col_ff <= w_last_ff) && (out_row_ff <= h_last_ff), "result position outside the frame")
   `LF3_ASSERT_IMPLIES(a_pend_single_row, pend_ff, h_last_ff == '0, "double shift pending outside a single-row frame")
   `LF3_ASSERT_NEXT(a_restart_after_last, do_push && do_emit && out_last, (in_row_ff == '0) && (in_col_ff == '0) && (out_row_ff == '0) && (out_col_ff == '0), "counters not cleared after the last result of a frame")
   `LF3_ASSERT_NEXT(a_rsp_not_overwritten, rsp_valid_ff && !rsp_ch.ready, rsp_valid_ff && $stable(rsp_data_ff), "stalled result lost or overwritten")

endmodule

@@ hdl/lf3_line_ram.sv @@
// Combined line store of the Laplacian filter: both buffered rows, one column per entry.
// Depends on lf3_pkg; one read and one write per cycle, read data registered.
module lf3_line_ram (
   input  logic                   clock,
   input  logic                   reset,
   input  lf3_pkg::line_rd_type   rd,
   output lf3_pkg::line_pair_type rd_data,
   input  lf3_pkg::line_wr_type   wr
);

   lf3_pkg::line_pair_type line_mem [lf3_pkg::MAX_WIDTH];
   lf3_pkg::line_pair_type mem_q_ff;
   lf3_pkg::line_pair_type fwd_data_ff;
   logic                   fwd_ff;
   logic                   fwd_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         mem_q_ff    <= line_mem[rd.addr];
         fwd_data_ff <= wr.data;
      end
   end

   // A read that meets a write to the same column in the same cycle sees the old
   // entry from the array, so the new data is carried alongside and chosen instead.
   always_comb begin
      fwd_in = fwd_ff;
      if (rd.en) begin
         fwd_in = wr.en && (wr.addr == rd.addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : mem_q_ff;

endmodule

@@ tb/laplace_filter_3x3_rgb_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for laplace_filter_3x3_rgb, the four-neighbour Laplacian RGB filter.
// Depends on lf3_pkg and the lf3 channel interfaces; it predicts every result and checks it.
module laplace_filter_3x3_rgb_tb;
   import lf3_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   // Covers items that may still be in the pipeline, with room to spare.
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_GAP       = 18;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int REPORT_LIMIT  = 10;

   // Register indexes past the end of the register file; writes to them must do nothing.
   localparam csr_index_type CSR_SPARE_2 = csr_index_type'(2'd2);
   localparam csr_index_type CSR_SPARE_3 = csr_index_type'(2'd3);

   // One result of the filter: the three channels and the end-of-frame mark.
   typedef struct packed {
      pixel_type colour;
      logic      frame_end;
   } filtered_item_t;

   logic clock = 1'b0;
   logic reset;

   lf3_req_if req_ch ();
   lf3_rsp_if rsp_ch ();
   lf3_csr_if csr_ch ();

   laplace_filter_3x3_rgb DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Predicted results, oldest first, waiting for the block to produce them.
   filtered_item_t expected_pixels[$];
   int failures      = 0;
   int checked_count = 0;
   int taken_count   = 0;
   int cycle_count   = 0;
   // When set, neither side idles: used for long stretches at full rate.
   bit steady_flow   = 1'b0;

   // -------------------------------------------------------------------------
   // Filter predictor: its own copy of the registers, line stores, window and
   // counters. Every accepted item is applied here in acceptance order.
   // -------------------------------------------------------------------------
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   pixel_type        upper_row  [MAX_WIDTH];
   pixel_type        middle_row [MAX_WIDTH];
   pixel_type        win        [9];
   int               col_in;
   int               row_in;
   int               out_pos;
   bit               item_taken;
   bit               frame_done;

   function automatic int eff_dim(logic [DIM_W-1:0] value, int top);
      if (value == 0) return 1;
      if (value > top) return top;
      return value;
   endfunction

   function automatic logic [CHAN_W-1:0] laplace_level(int centre, int up, int down,
                                                         int left, int right);
      int acc;
      acc = 4 * centre - up - down - left - right;
      // Integer division in SystemVerilog truncates toward zero, as required.
      acc = acc / 8 + RESULT_OFFSET;
      return acc[CHAN_W-1:0];
   endfunction

   task automatic filter_reset();
      cfg_width  = FRAME_WIDTH_RESET;
      cfg_height = FRAME_HEIGHT_RESET;
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_in  = 0;
      row_in  = 0;
      out_pos = 0;
   endtask

   task automatic filter_config(csr_index_type idx, logic [DIM_W-1:0] value);
      if (idx == CSR_FRAME_WIDTH || idx == CSR_FRAME_HEIGHT) begin
         if (idx == CSR_FRAME_WIDTH) cfg_width = value;
         else cfg_height = value;
         // Any real register write restarts the frame; stores and window are kept.
         col_in  = 0;
         row_in  = 0;
         out_pos = 0;
      end
   endtask

   // Shifts one pixel into the window and the line stores at the input column.
   task automatic shift_window(pixel_type px, int w);
      int col;
      col = col_in % MAX_WIDTH;
      for (int r = 0; r < 3; r++) begin
         win[r * 3]     = win[r * 3 + 1];
         win[r * 3 + 1] = win[r * 3 + 2];
      end
      win[2] = upper_row[col];
      win[5] = middle_row[col];
      win[8] = px;
      upper_row[col]  = middle_row[col];
      middle_row[col] = px;
      col_in++;
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
   endtask

   // Works out the result for the pixel at out_pos from the window centre.
   task automatic emit_result(int w, int h);
      int r;
      int c;
      filtered_item_t res;
      r = out_pos / w;
      c = out_pos % w;
      res.colour    = win[4];
      res.frame_end = (out_pos == w * h - 1);
      if (r != 0 && r != h - 1 && c != 0 && c != w - 1) begin
         res.colour.red   = laplace_level(win[4].red, win[1].red, win[7].red,
                                          win[3].red, win[5].red);
         res.colour.green = laplace_level(win[4].green, win[1].green, win[7].green,
                                          win[3].green, win[5].green);
         res.colour.blue  = laplace_level(win[4].blue, win[1].blue, win[7].blue,
                                          win[3].blue, win[5].blue);
      end
      expected_pixels.push_back(res);
      if (res.frame_end) begin
         col_in     = 0;
         row_in     = 0;
         out_pos    = 0;
         frame_done = 1'b1;
      end else begin
         out_pos++;
      end
   endtask

   task automatic laplace_predict(cmd_type cmd, pixel_type px);
      int w;
      int h;
      int pos;
      w = eff_dim(cfg_width, MAX_WIDTH);
      h = eff_dim(cfg_height, MAX_HEIGHT);
      pos = row_in * w + col_in;
      item_taken = 1'b0;
      if (cmd == CMD_PIXEL) begin
         // Pixels after the frame is fully in are dropped until it is flushed.
         if (row_in < h) begin
            item_taken = 1'b1;
            shift_window(px, w);
            if (pos >= w + 1) emit_result(w, h);
         end
      end else if (row_in >= h) begin
         // A flush pushes a blank pixel; in a single-row frame the first one pushes two.
         item_taken = 1'b1;
         shift_window('0, w);
         if (pos < w + 1) shift_window('0, w);
         emit_result(w, h);
      end
      if (item_taken) taken_count++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   function automatic logic [CHAN_W-1:0] random_level();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      px.red   = random_level();
      px.green = random_level();
      px.blue  = random_level();
      return px;
   endfunction

   // Sends one item after a random gap. Valid is left high on acceptance so that
   // a following item with no gap keeps it high without a glitch.
   task automatic push_item(cmd_type cmd, pixel_type px);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= cmd;
      req_ch.red_in   <= px.red;
      req_ch.green_in <= px.green;
      req_ch.blue_in  <= px.blue;
      do @(posedge clock); while (!req_ch.ready);
      laplace_predict(cmd, px);
   endtask

   // Lets every outstanding result arrive, then waits SETTLE_CYCLES more for items
   // that give no result but may still be moving through the pipeline.
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [DIM_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      filter_config(idx, value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Carries the current frame on from wherever the predictor stands: pixels until
   // the frame is in, then flushes until its last result. With noise_pct above zero,
   // stray flushes come before pixels and stray pixels after the input, all of which
   // the block must drop. cut_after >= 0 abandons the frame after that many items.
   task automatic stream_frame(int noise_pct, int cut_after);
      int h;
      int sent;
      h = eff_dim(cfg_height, MAX_HEIGHT);
      sent = 0;
      frame_done = 1'b0;
      while (row_in < h && sent != cut_after) begin
         if ($urandom_range(0, 99) < noise_pct) push_item(CMD_FLUSH, random_pixel());
         push_item(CMD_PIXEL, random_pixel());
         sent++;
      end
      if (sent != cut_after && $urandom_range(0, 99) < noise_pct)
         repeat ($urandom_range(1, 3)) push_item(CMD_PIXEL, random_pixel());
      while (!frame_done && sent != cut_after) begin
         push_item(CMD_FLUSH, random_pixel());
         sent++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // A 4x3 frame with hand-picked pixels. The two interior pixels hit the top
   // of the range (bright centre, dark neighbours), the bottom of the range, a
   // small negative sum that must truncate up to 128 and one that truncates to
   // 127 rather than 126. A stray flush mid-frame, a stray pixel after the
   // input, and a one-pixel frame are also covered.
   task automatic test_directed_frame();
      logic [23:0] frame4x3 [12];
      frame4x3 = '{24'hFF0000, 24'h000102, 24'hFF0003, 24'h0080FF,
                   24'h000001, 24'hFF0301, 24'h000000, 24'hFFFF02,
                   24'hFFFFFF, 24'h000002, 24'hFF8003, 24'h000000};
      // A few pixels at the reset size: far too early to give a result.
      repeat (3) push_item(CMD_PIXEL, random_pixel());
      quiesce();
      write_register(CSR_FRAME_WIDTH, 11'd4);
      write_register(CSR_FRAME_HEIGHT, 11'd3);
      for (int i = 0; i < 12; i++) begin
         if (i == 7) push_item(CMD_FLUSH, pixel_type'(24'hFFFFFF));
         push_item(CMD_PIXEL, pixel_type'(frame4x3[i]));
      end
      push_item(CMD_PIXEL, pixel_type'(24'hFFFFFF));
      frame_done = 1'b0;
      while (!frame_done) push_item(CMD_FLUSH, pixel_type'(24'h000000));
      quiesce();
      write_register(CSR_FRAME_WIDTH, 11'd1);
      write_register(CSR_FRAME_HEIGHT, 11'd1);
      push_item(CMD_PIXEL, pixel_type'(24'hA55AC3));
      push_item(CMD_FLUSH, pixel_type'(24'h5AA53C));
   endtask

   // Writes to indexes past the register file must leave a frame in progress
   // alone; a real write part-way must restart it.
   task automatic test_register_writes();
      quiesce();
      write_register(CSR_FRAME_WIDTH, 11'd3);
      write_register(CSR_FRAME_HEIGHT, 11'd3);
      stream_frame(0, 4);
      quiesce();
      write_register(CSR_SPARE_2, 11'h7FF);
      write_register(CSR_SPARE_3, 11'h000);
      stream_frame(0, -1);
      quiesce();
      write_register(CSR_FRAME_WIDTH, 11'd5);
      write_register(CSR_FRAME_HEIGHT, 11'd2);
      stream_frame(0, 7);
      quiesce();
      write_register(CSR_FRAME_HEIGHT, 11'd2);
      stream_frame(0, -1);
      // Straight into the next frame with no write in between.
      stream_frame(0, -1);
   endtask

   // Largest and clamped sizes; all but the last run at full rate to keep the run short.
   task automatic test_dimension_extremes();
      quiesce();
      steady_flow = 1'b1;
      write_register(CSR_FRAME_WIDTH, 11'd1024);
      write_register(CSR_FRAME_HEIGHT, 11'd3);
      stream_frame(0, -1);
      quiesce();
      // Over the top: clamps to 1024 wide, and a single row.
      write_register(CSR_FRAME_WIDTH, 11'h7FF);
      write_register(CSR_FRAME_HEIGHT, 11'd1);
      stream_frame(0, -1);
      quiesce();
      // Zero width clamps to one column; height over the top clamps to 1024 rows.
      write_register(CSR_FRAME_WIDTH, 11'd0);
      write_register(CSR_FRAME_HEIGHT, 11'h7FF);
      stream_frame(0, -1);
      quiesce();
      steady_flow = 1'b0;
      write_register(CSR_FRAME_WIDTH, 11'd7);
      write_register(CSR_FRAME_HEIGHT, 11'd0);
      stream_frame(0, -1);
   endtask

   // Mostly well-formed frames of random small sizes with random content, some
   // with stray items, and some abandoned part-way and restarted by a write.
   task automatic test_random_frames();
      int start_count;
      int w;
      int h;
      int kind;
      start_count = taken_count;
      while (taken_count - start_count < RANDOM_ITEMS) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            h = $urandom_range(1, 6);
            quiesce();
            write_register(CSR_FRAME_WIDTH, DIM_W'(w));
            write_register(CSR_FRAME_HEIGHT, DIM_W'(h));
         end
         w = eff_dim(cfg_width, MAX_WIDTH);
         h = eff_dim(cfg_height, MAX_HEIGHT);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            stream_frame(5, $urandom_range(0, w * h + w));
            quiesce();
            write_register(CSR_FRAME_WIDTH, cfg_width);
         end else if (kind == 1) begin
            stream_frame(15, -1);
         end else begin
            stream_frame(0, -1);
         end
      end
      steady_flow = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls on ready, and a checker at every accepted result.
   // -------------------------------------------------------------------------
   function automatic void log_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
   endfunction

   initial begin : result_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : check_results
      filtered_item_t want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            log_failure($sformatf("result %0d arrived with none expected: %h %h %h end=%b",
                                  checked_count, rsp_ch.red_out, rsp_ch.green_out,
                                  rsp_ch.blue_out, rsp_ch.frame_end));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_ch.red_out !== want.colour.red)
               log_failure($sformatf("result %0d red: expected %h, got %h",
                                     checked_count, want.colour.red, rsp_ch.red_out));
            if (rsp_ch.green_out !== want.colour.green)
               log_failure($sformatf("result %0d green: expected %h, got %h",
                                     checked_count, want.colour.green, rsp_ch.green_out));
            if (rsp_ch.blue_out !== want.colour.blue)
               log_failure($sformatf("result %0d blue: expected %h, got %h",
                                     checked_count, want.colour.blue, rsp_ch.blue_out));
            if (rsp_ch.frame_end !== want.frame_end)
               log_failure($sformatf("result %0d frame_end: expected %b, got %b",
                                     checked_count, want.frame_end, rsp_ch.frame_end));
         end
         checked_count++;
      end
   end

   // Watchdog: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_pixels.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.command  <= CMD_PIXEL;
      req_ch.red_in   <= '0;
      req_ch.green_in <= '0;
      req_ch.blue_in  <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= CSR_FRAME_WIDTH;
      csr_ch.data     <= '0;
      filter_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frame();
      test_register_writes();
      test_dimension_extremes();
      test_random_frames();

      quiesce();
      if (failures == 0 && expected_pixels.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (expected_pixels.size() != 0)
            $display("%0d expected results never arrived", expected_pixels.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
